>>> rtl/core/chc_pkg.sv
`default_nettype none
package chc_pkg;

    // sizing
    localparam int MAX_HITS   = 4096;
    localparam int COORD_BITS = 24;
    localparam int CFG_W      = (COORD_BITS > 24) ? COORD_BITS : 24;
    localparam int CNT_W      = $clog2(MAX_HITS + 1);
    localparam int RT_W       = 25;
    localparam int FRAC_W     = 16;
    localparam int SUM_W      = 37;

    // register indexes
    localparam logic [2:0] REG_APEX_X = 3'd0;
    localparam logic [2:0] REG_APEX_Y = 3'd1;
    localparam logic [2:0] REG_APEX_Z = 3'd2;
    localparam logic [2:0] REG_AXIS_X = 3'd3;
    localparam logic [2:0] REG_AXIS_Y = 3'd4;
    localparam logic [2:0] REG_AXIS_Z = 3'd5;
    localparam logic [2:0] REG_LENGTH = 3'd6;
    localparam logic [2:0] REG_TAN    = 3'd7;

    // input item
    typedef struct packed {
        logic signed [COORD_BITS-1:0] hit_x;
        logic signed [COORD_BITS-1:0] hit_y;
        logic signed [COORD_BITS-1:0] hit_z;
        logic                         hit_present;
        logic                         last_hit;
    } t_hit_in;

    // result item
    typedef struct packed {
        logic [RT_W-1:0]   mean_transverse;
        logic [FRAC_W-1:0] contained_fraction;
        logic [CNT_W-1:0]  hits_seen;
    } t_result;

    // classified hit, front to back
    typedef struct packed {
        logic [RT_W-1:0] rt;
        logic            in_cone;
        logic            hit;
        logic            last;
    } t_cls;

endpackage
`default_nettype wire

>>> rtl/core/chc_front.sv
`default_nettype none
module chc_front
    import chc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_hit_in          i_in,
    output logic                  o_item_valid,
    input  wire logic             i_item_ready,
    output t_cls                  o_item
);

    localparam int WIDE = 34;
    localparam int D_W  = 26;
    localparam int P_W  = 42;
    localparam int C_W  = 43;
    localparam int RL_W = 44;
    localparam int M_W  = 31;
    localparam int SQ_W = 62;
    localparam int RLT_W = 55;
    localparam logic signed [WIDE-1:0] D_LIM = 34'sd16777216;
    localparam logic [SQ_W-1:0] SQ_BIT0 = 62'd1 << 60;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DISP = 3'd1;
    localparam logic [2:0] F_MUL  = 3'd2;
    localparam logic [2:0] F_CRS  = 3'd3;
    localparam logic [2:0] F_SQR  = 3'd4;
    localparam logic [2:0] F_SUM  = 3'd5;
    localparam logic [2:0] F_ROOT = 3'd6;
    localparam logic [2:0] F_PUSH = 3'd7;

    function automatic logic signed [D_W-1:0] clamp_d(input logic signed [WIDE-1:0] v);
        logic signed [WIDE-1:0] t;
        t = v;
        if (v > D_LIM) t = D_LIM;
        if (v < -D_LIM) t = -D_LIM;
        return D_W'(t);
    endfunction

    function automatic logic [M_W-1:0] mag(input logic signed [C_W-1:0] c);
        logic [C_W-1:0] a;
        a = (c < 0) ? C_W'(-c) : C_W'(c);
        return a[40:10];
    endfunction

    logic [2:0] r_st, n_st;

    // configuration
    logic signed [COORD_BITS-1:0] r_apx, r_apy, r_apz;
    logic signed [15:0] r_axx, r_axy, r_axz;
    logic [23:0] r_len;
    logic [15:0] r_tan;

    // datapath
    logic signed [COORD_BITS-1:0] r_hx, r_hy, r_hz;
    logic r_pres, r_last;
    logic signed [D_W-1:0] r_dx, r_dy, r_dz;
    logic signed [P_W-1:0] r_pxx, r_pyy, r_pzz, r_pyz, r_pzy, r_pzx, r_pxz, r_pxy, r_pyx;
    logic signed [RL_W-1:0] r_rl;
    logic [M_W-1:0] r_mx, r_my, r_mz;
    logic [SQ_W-1:0] r_sqx, r_sqy, r_sqz;
    logic r_rlok;
    logic [RLT_W-1:0] r_rlt;
    logic [SQ_W-1:0] r_x, r_res, r_bit;
    logic [SQ_W-1:0] w_try;
    logic w_ge;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apx <= '0;
            r_apy <= '0;
            r_apz <= '0;
            r_axx <= '0;
            r_axy <= '0;
            r_axz <= 16'sd32767;
            r_len <= '0;
            r_tan <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_APEX_X: r_apx <= i_cfg_data[COORD_BITS-1:0];
                REG_APEX_Y: r_apy <= i_cfg_data[COORD_BITS-1:0];
                REG_APEX_Z: r_apz <= i_cfg_data[COORD_BITS-1:0];
                REG_AXIS_X: r_axx <= i_cfg_data[15:0];
                REG_AXIS_Y: r_axy <= i_cfg_data[15:0];
                REG_AXIS_Z: r_axz <= i_cfg_data[15:0];
                REG_LENGTH: r_len <= i_cfg_data[23:0];
                REG_TAN:    r_tan <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_st = r_st;
        case (r_st)
            F_IDLE: if (i_in_valid) n_st = i_in.hit_present ? F_DISP : F_PUSH;
            F_DISP: n_st = F_MUL;
            F_MUL:  n_st = F_CRS;
            F_CRS:  n_st = F_SQR;
            F_SQR:  n_st = F_SUM;
            F_SUM:  n_st = F_ROOT;
            F_ROOT: if (r_bit[0]) n_st = F_PUSH;
            F_PUSH: if (i_item_ready) n_st = F_IDLE;
            default: n_st = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= F_IDLE;
        else          r_st <= n_st;
    end

    // one square-root bit per step
    assign w_try = r_res + r_bit;
    assign w_ge  = (r_x >= w_try);

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_st == F_IDLE && i_in_valid) begin
            r_hx   <= i_in.hit_x;
            r_hy   <= i_in.hit_y;
            r_hz   <= i_in.hit_z;
            r_pres <= i_in.hit_present;
            r_last <= i_in.last_hit;
        end
        if (r_st == F_DISP) begin
            r_dx <= clamp_d(WIDE'(r_hx) - WIDE'(r_apx));
            r_dy <= clamp_d(WIDE'(r_hy) - WIDE'(r_apy));
            r_dz <= clamp_d(WIDE'(r_hz) - WIDE'(r_apz));
        end
        if (r_st == F_MUL) begin
            r_pxx <= P_W'(r_dx) * P_W'(r_axx);
            r_pyy <= P_W'(r_dy) * P_W'(r_axy);
            r_pzz <= P_W'(r_dz) * P_W'(r_axz);
            r_pyz <= P_W'(r_dy) * P_W'(r_axz);
            r_pzy <= P_W'(r_dz) * P_W'(r_axy);
            r_pzx <= P_W'(r_dz) * P_W'(r_axx);
            r_pxz <= P_W'(r_dx) * P_W'(r_axz);
            r_pxy <= P_W'(r_dx) * P_W'(r_axy);
            r_pyx <= P_W'(r_dy) * P_W'(r_axx);
        end
        if (r_st == F_CRS) begin
            r_rl <= RL_W'(r_pxx) + RL_W'(r_pyy) + RL_W'(r_pzz);
            r_mx <= mag(C_W'(r_pyz) - C_W'(r_pzy));
            r_my <= mag(C_W'(r_pzx) - C_W'(r_pxz));
            r_mz <= mag(C_W'(r_pxy) - C_W'(r_pyx));
        end
        if (r_st == F_SQR) begin
            r_sqx <= SQ_W'(r_mx) * SQ_W'(r_mx);
            r_sqy <= SQ_W'(r_my) * SQ_W'(r_my);
            r_sqz <= SQ_W'(r_mz) * SQ_W'(r_mz);
            r_rlok <= (r_rl >= 0) && (r_rl <= $signed({5'b0, r_len, 15'b0}));
            r_rlt <= RLT_W'(r_rl[38:0]) * RLT_W'(r_tan);
        end
        if (r_st == F_SUM) begin
            r_x   <= r_sqx + r_sqy + r_sqz;
            r_res <= '0;
            r_bit <= SQ_BIT0;
        end
        if (r_st == F_ROOT) begin
            if (w_ge) begin
                r_x   <= r_x - w_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // classified item
    always_comb begin
        o_in_ready     = (r_st == F_IDLE);
        o_item_valid   = (r_st == F_PUSH);
        o_item.hit     = r_pres;
        o_item.last    = r_last;
        o_item.rt      = r_res[30] ? {RT_W{1'b1}} : r_res[29:5];
        o_item.in_cone = r_rlok && (r_rlt > {2'b0, r_res[30:0], 22'b0});
    end

endmodule
`default_nettype wire

>>> rtl/core/chc_fifo.sv
`default_nettype none
module chc_fifo
    import chc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  wire t_cls i_wr_item,
    output logic      o_rd_valid,
    input  wire logic i_rd_ready,
    output t_cls      o_rd_item
);

    t_cls       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_item  = r_mem[r_rp];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_wr_item;
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/chc_back.sv
`default_nettype none
module chc_back
    import chc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_item_valid,
    output logic      o_item_ready,
    input  wire t_cls i_item,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_result   o_out
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_PREP = 3'd1;
    localparam logic [2:0] B_RUNM = 3'd2;
    localparam logic [2:0] B_RUNF = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;
    localparam int IT_W = $clog2(SUM_W);

    logic [2:0] r_st;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt, r_ins;
    logic [SUM_W-1:0] r_dvd, w_dvd;
    logic [CNT_W-1:0] r_rem, w_rem;
    logic [CNT_W:0]   w_sh;
    logic             w_ge;
    logic [IT_W-1:0]  r_it;
    logic [RT_W-1:0]  r_mean;
    logic [FRAC_W-1:0] r_frac;
    logic r_ov;
    t_result r_out;
    logic w_pop, w_load;

    assign o_item_ready = (r_st == B_IDLE);
    assign w_pop  = i_item_valid && o_item_ready;
    assign w_load = (r_st == B_OUT) && (!r_ov || i_out_ready);

    // restoring divide step, one quotient bit
    always_comb begin
        w_sh  = {r_rem, r_dvd[SUM_W-1]};
        w_ge  = (w_sh >= {1'b0, r_cnt});
        w_rem = w_ge ? CNT_W'(w_sh - {1'b0, r_cnt}) : CNT_W'(w_sh);
        w_dvd = {r_dvd[SUM_W-2:0], w_ge};
    end

    // control and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= B_IDLE;
            r_sum <= '0;
            r_cnt <= '0;
            r_ins <= '0;
            r_ov  <= 1'b0;
        end else begin
            case (r_st)
                B_IDLE: begin
                    if (w_pop) begin
                        if (i_item.hit && r_cnt < CNT_W'(MAX_HITS)) begin
                            r_sum <= r_sum + SUM_W'(i_item.rt);
                            r_cnt <= r_cnt + 1'b1;
                            r_ins <= r_ins + CNT_W'(i_item.in_cone);
                        end
                        if (i_item.last) r_st <= B_PREP;
                    end
                end
                B_PREP: r_st <= (r_cnt == '0) ? B_OUT : B_RUNM;
                B_RUNM: if (r_it == '0) r_st <= B_RUNF;
                B_RUNF: if (r_it == '0) r_st <= B_OUT;
                B_OUT: begin
                    if (w_load) begin
                        r_sum <= '0;
                        r_cnt <= '0;
                        r_ins <= '0;
                        r_st  <= B_IDLE;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
            if (w_load)                 r_ov <= 1'b1;
            else if (r_ov && i_out_ready) r_ov <= 1'b0;
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            B_PREP: begin
                r_dvd  <= r_sum;
                r_rem  <= '0;
                r_it   <= IT_W'(SUM_W - 1);
                r_mean <= '0;
                r_frac <= '0;
            end
            B_RUNM: begin
                if (r_it == '0) begin
                    r_mean <= w_dvd[RT_W-1:0];
                    r_dvd  <= SUM_W'({r_ins, 16'b0});
                    r_rem  <= '0;
                    r_it   <= IT_W'(SUM_W - 1);
                end else begin
                    r_dvd <= w_dvd;
                    r_rem <= w_rem;
                    r_it  <= r_it - 1'b1;
                end
            end
            B_RUNF: begin
                r_dvd <= w_dvd;
                r_rem <= w_rem;
                r_it  <= r_it - 1'b1;
                if (r_it == '0) r_frac <= w_dvd[16] ? {FRAC_W{1'b1}} : w_dvd[15:0];
            end
            default: ;
        endcase
        if (w_load) begin
            r_out.mean_transverse    <= r_mean;
            r_out.contained_fraction <= r_frac;
            r_out.hits_seen          <= r_cnt;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule
`default_nettype wire

>>> rtl/core/cone_hit_containment.sv
// cone_hit_containment: point-in-cone test over the hits of one cluster.
// Input channel (i_in_valid/o_in_ready/i_in) carries one hit or end marker
// per item; last_hit closes the cluster. Result channel (o_out_valid/
// i_out_ready/o_out) gives one item per closed cluster: floor mean
// transverse distance, contained fraction in Q0.16 and the hit count.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
// to be written by the user while the block is idle; the block does not
// enforce this. Front end: each hit passes the accept state, five setup
// stages (DISP, MUL, CRS, SQR, SUM), the bit-serial square root (31 steps)
// and the hand-off state; an end marker without a hit goes from accept
// straight to hand-off, and a new item is taken only in the accept state.
// The back end takes one item per cycle from a two-item queue while it
// accumulates and none while it divides or waits to load its output, so
// it accumulates while the front end works on the next hit. A result goes
// through the front end, the queue, a setup state, shared restoring
// division (mean, then fraction) and the output register; an empty
// cluster's result skips the division. The output register holds a result
// while the receiver stalls; the queue and front end keep working until
// the queue is full. Reset (synchronous, active low) clears accumulators,
// configuration to its defaults and all valid flags.
`default_nettype none
module cone_hit_containment
    import chc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_hit_in          i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_result               o_out
);

    logic f_valid, f_ready, q_valid, q_ready;
    t_cls f_item, q_item;

    // classify hits
    chc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_item       (f_item)
    );

    // decoupling queue
    chc_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_item  (f_item),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_item  (q_item)
    );

    // accumulate and divide
    chc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire

>>> rtl/core/chc_checker.sv
`default_nettype none
module chc_checker
    import chc_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    o_out_valid,
    input wire logic    i_out_ready,
    input wire t_result o_out
);

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed under stall");

    // nothing shown after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // empty cluster gives zeros
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.hits_seen == '0 |->
            o_out.mean_transverse == '0 && o_out.contained_fraction == '0)
        else $error("empty cluster with nonzero result");

    // hit count capped
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.hits_seen <= CNT_W'(MAX_HITS))
        else $error("hit count beyond cap");

endmodule

bind cone_hit_containment chc_checker u_chc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire

>>> tb/sv/chc_checker.sv
`default_nettype none
module chc_scoreboard
    import chc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire t_hit_in          i_in,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_result          i_out,
    output int                    o_errors,
    output int                    o_pending
);

    // cone shadow registers
    longint cone_apex [3];
    longint cone_axis [3];
    longint cone_len;
    longint cone_tan;

    // cluster accumulators
    longint rt_total;
    int     hit_cnt;
    int     inside_cnt;

    // expected results, ring of slots
    t_result exp_store [16];
    int      exp_head;
    int      exp_tail;

    // floor square root, bit by bit
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_span(input longint v);
        if (v > 64'sd16777216) return 64'sd16777216;
        if (v < -64'sd16777216) return -64'sd16777216;
        return v;
    endfunction

    function automatic longint unsigned cut_mag(input longint c);
        longint unsigned m;
        m = (c < 0) ? longint'(-c) : longint'(c);
        return m >> 10;
    endfunction

    // one hit against the current cone
    task automatic accumulate_hit(input t_hit_in h);
        longint d [3];
        longint rl, cx, cy, cz;
        longint unsigned mx, my, mz, fine, rt;
        d[0] = clamp_span(longint'(h.hit_x) - cone_apex[0]);
        d[1] = clamp_span(longint'(h.hit_y) - cone_apex[1]);
        d[2] = clamp_span(longint'(h.hit_z) - cone_apex[2]);
        rl = d[0] * cone_axis[0] + d[1] * cone_axis[1] + d[2] * cone_axis[2];
        cx = d[1] * cone_axis[2] - d[2] * cone_axis[1];
        cy = d[2] * cone_axis[0] - d[0] * cone_axis[2];
        cz = d[0] * cone_axis[1] - d[1] * cone_axis[0];
        mx = cut_mag(cx);
        my = cut_mag(cy);
        mz = cut_mag(cz);
        fine = floor_root(mx * mx + my * my + mz * mz);
        rt = fine >> 5;
        if (rt > 33554431) rt = 33554431;
        rt_total += rt;
        hit_cnt++;
        if (rl >= 0 && rl <= (cone_len << 15)) begin
            if (longint'(rl) * cone_tan > longint'(fine << 22)) inside_cnt++;
        end
    endtask

    // prediction and comparison
    always @(posedge i_clk) begin
        t_result want;
        longint unsigned mean, frac;
        if (!i_rst_n) begin
            cone_apex = '{0, 0, 0};
            cone_axis = '{0, 0, 32767};
            cone_len = 0;
            cone_tan = 0;
            rt_total = 0;
            hit_cnt = 0;
            inside_cnt = 0;
            exp_head = 0;
            exp_tail = 0;
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_APEX_X: cone_apex[0] = longint'($signed(i_cfg_data[23:0]));
                    REG_APEX_Y: cone_apex[1] = longint'($signed(i_cfg_data[23:0]));
                    REG_APEX_Z: cone_apex[2] = longint'($signed(i_cfg_data[23:0]));
                    REG_AXIS_X: cone_axis[0] = longint'($signed(i_cfg_data[15:0]));
                    REG_AXIS_Y: cone_axis[1] = longint'($signed(i_cfg_data[15:0]));
                    REG_AXIS_Z: cone_axis[2] = longint'($signed(i_cfg_data[15:0]));
                    REG_LENGTH: cone_len = longint'(i_cfg_data[23:0]);
                    REG_TAN:    cone_tan = longint'(i_cfg_data[15:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.hit_present && hit_cnt < MAX_HITS) accumulate_hit(i_in);
                if (i_in.last_hit) begin
                    mean = 0;
                    frac = 0;
                    if (hit_cnt != 0) begin
                        mean = rt_total / hit_cnt;
                        frac = (longint'(inside_cnt) << 16) / hit_cnt;
                        if (mean > 33554431) mean = 33554431;
                        if (frac > 65535) frac = 65535;
                    end
                    want.mean_transverse = mean[RT_W-1:0];
                    want.contained_fraction = frac[FRAC_W-1:0];
                    want.hits_seen = hit_cnt[CNT_W-1:0];
                    exp_store[exp_tail % 16] = want;
                    exp_tail++;
                    rt_total = 0;
                    hit_cnt = 0;
                    inside_cnt = 0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (exp_tail == exp_head) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result item %p", i_out);
                end else begin
                    want = exp_store[exp_head % 16];
                    exp_head++;
                    if (want.mean_transverse != i_out.mean_transverse
                        || want.contained_fraction != i_out.contained_fraction
                        || want.hits_seen != i_out.hits_seen) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("result mismatch: expected %p got %p", want, i_out);
                    end
                end
            end
        end
        o_pending = exp_tail - exp_head;
    end

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none
module tb_top;
    import chc_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [2:0]       cfg_idx = REG_APEX_X;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_hit_in          in_item = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_result          out_item;
    int               errors;
    int               pending;
    int               quiet_cycles = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    logic [23:0]      cone_regs [8];

    always #6 clk = ~clk;

    cone_hit_containment i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item)
    );

    chc_scoreboard i_check (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_item),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no item moving
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [23:0] x, y, z, input logic present, last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{hit_x: x, hit_y: y, hit_z: z, hit_present: present, last_hit: last};
        forever begin
            @(negedge clk);
            if (in_ready) break;
        end
        @(posedge clk);
    endtask

    // drain, then write all cone registers
    task automatic load_cone();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        for (int r = 0; r < 8; r++) begin
            cfg_we <= 1'b1;
            cfg_idx <= r[2:0];
            cfg_data <= cone_regs[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_cone();
        int pick;
        pick = $urandom_range(5);
        for (int r = 0; r < 3; r++) cone_regs[r] = 24'($urandom);
        for (int r = 3; r < 6; r++) cone_regs[r] = '0;
        if (pick < 3) begin
            cone_regs[3 + pick] = ($urandom_range(1)) ? 24'h007FFF : 24'h008001;
        end else if (pick == 3) begin
            // diagonal axis, y component negative
            cone_regs[3] = 24'd18918;
            cone_regs[4] = 24'h00B61A;
            cone_regs[5] = 24'd18918;
        end else begin
            for (int r = 3; r < 6; r++) cone_regs[r] = 24'($urandom_range(65535));
        end
        cone_regs[6] = ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom_range(200000));
        cone_regs[7] = ($urandom_range(7) == 0) ? 24'h00FFFF : 24'($urandom_range(16000));
    endtask

    // hit near the apex, sometimes anywhere
    task automatic random_hit(input logic last);
        logic [23:0] c [3];
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(7) == 0) c[k] = 24'($urandom);
            else c[k] = cone_regs[k] + 24'($signed($urandom_range(100000)) - 50000);
        end
        send_item(c[0], c[1], c[2], 1'b1, last);
    endtask

    initial begin
        int pcts [4][2];
        int cl_size;
        pcts = '{'{0, 0}, '{76, 0}, '{0, 76}, '{14, 14}};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default cone: empty cluster, ignored item, hit with last
        send_item(24'h0, 24'h0, 24'h0, 1'b0, 1'b1);
        send_item(24'h123456, 24'h0, 24'h0, 1'b0, 1'b0);
        send_item(24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b1);

        // 45 degree cone along z
        cone_regs = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h007FFF, 24'd1000, 24'd4096};
        load_cone();
        send_item(24'd0, 24'd0, 24'd500, 1'b1, 1'b0);
        send_item(24'd100, 24'd0, 24'd500, 1'b1, 1'b0);
        send_item(24'd600, 24'd0, 24'd500, 1'b1, 1'b0);
        send_item(24'd0, 24'd0, -24'sd5, 1'b1, 1'b0);
        send_item(24'd0, 24'd0, 24'd2000, 1'b1, 1'b0);
        send_item(24'd0, 24'd0, 24'd0, 1'b1, 1'b0);
        send_item(24'd0, 24'd0, 24'd0, 1'b0, 1'b1);

        // extreme registers and coordinates
        cone_regs = '{24'h800000, 24'h800000, 24'h800000, 24'h008000, 24'h008000,
                      24'h008000, 24'hFFFFFF, 24'h00FFFF};
        load_cone();
        send_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0);
        send_item(24'h800000, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0);
        send_item(24'h7FFFFF, 24'h800000, 24'h000000, 1'b1, 1'b1);
        cone_regs = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h007FFF, 24'h007FFF,
                      24'h007FFF, 24'h000000, 24'h000000};
        load_cone();
        send_item(24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0);
        send_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b1);

        // random clusters under each idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            random_cone();
            load_cone();
            send_idle_pct = pcts[ph][0];
            recv_stall_pct = pcts[ph][1];
            for (int n = 0; n < 160; n += cl_size) begin
                cl_size = $urandom_range(12, 1);
                for (int k = 0; k < cl_size; k++) begin
                    if ($urandom_range(19) == 0) begin
                        send_item(24'($urandom), 24'($urandom), 24'($urandom), 1'b0, 1'b0);
                    end
                    random_hit(k == cl_size - 1 && $urandom_range(7) != 0);
                end
                if ($urandom_range(9) == 0) begin
                    send_item(24'($urandom), 24'($urandom), 24'($urandom), 1'b0, 1'b1);
                end else begin
                    send_item(24'h0, 24'h0, 24'h0, 1'b0, 1'b1);
                end
            end
        end

        in_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
